[hdl/ntcbt_pkg.sv]
// ----------------------------------------------------------------------------
// ntcbt_pkg
// Shared types and fixed-point constants for the NTC beta-equation converter.
// ----------------------------------------------------------------------------
package ntcbt_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_RES  = 2'd1,
    ST_NONPOS    = 2'd2,
    ST_SAT       = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NOM_RES  = 2'd0,
    CFG_BETA     = 2'd1,
    CFG_NOM_TEMP = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_index_t;

  // Widths of the configuration fields.
  localparam int NOM_RES_W = 20;
  localparam int BETA_W    = 16;
  localparam int NOM_T_W   = 16;
  localparam int CFG_W     = 20;

  // log2 result: 5 integer bits and 28 fraction bits.
  localparam int LOG_FRAC_W = 28;
  localparam int LOG_W      = 33;
  localparam logic [27:0] LN2_Q28 = 28'hB17217F;

  // Q40 terms of the denominator.
  localparam int Q_W   = 47;
  localparam int D_W   = 48;
  localparam int FIN_W = 53;
  localparam logic [Q_W-1:0]   T2_NUM  = 47'd100 << 40;
  localparam logic [FIN_W-1:0] FIN_NUM = 53'd6400 << 40;

  // Output scaling: tu = (q + 90) / 100, done as a reciprocal multiply.
  localparam int          ROUND_W   = 23;
  localparam logic [22:0] ROUND_ADD = 23'd90;
  localparam logic [52:0] SAT_LIMIT = 53'd5024910;
  localparam logic [23:0] RECIP_M   = 24'd10737419;
  localparam logic [16:0] ABS_ZERO  = 17'd17482;

endpackage

[hdl/ntcbt_log2.sv]
// ----------------------------------------------------------------------------
// ntcbt_log2
// Pipelined base-2 logarithm: five normalizing stages, then one squaring
// stage per fraction bit.
// ----------------------------------------------------------------------------
module ntcbt_log2 #(
  parameter int W      = 20,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [W-1:0]               x,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic [ntcbt_pkg::LOG_W-1:0] y,
  output logic [SIDE_W-1:0]          side_out
);

  localparam int FW = ntcbt_pkg::LOG_FRAC_W;

  logic              nv [0:5];
  logic [31:0]       nm [0:5];
  logic [4:0]        ne [0:5];
  logic [SIDE_W-1:0] ns [0:5];

  logic              sv [0:FW];
  logic [31:0]       sm [0:FW];
  logic [4:0]        se [0:FW];
  logic [FW-1:0]     sf [0:FW];
  logic [SIDE_W-1:0] ss [0:FW];

  assign nv[0] = in_valid;
  assign nm[0] = 32'(x);
  assign ne[0] = 5'd31;
  assign ns[0] = side_in;

  // Normalize the mantissa to the top bit, halving the shift each stage.
  for (genvar k = 0; k < 5; k++) begin : g_norm
    localparam int S = 16 >> k;
    always_ff @(posedge clk) begin
      if (rst) begin
        nv[k+1] <= 1'b0;
      end else begin
        nv[k+1] <= nv[k];
      end
      ns[k+1] <= ns[k];
      if (nm[k][31 -: S] == '0) begin
        nm[k+1] <= nm[k] << S;
        ne[k+1] <= ne[k] - 5'(S);
      end else begin
        nm[k+1] <= nm[k];
        ne[k+1] <= ne[k];
      end
    end
  end

  assign sv[0] = nv[5];
  assign sm[0] = nm[5];
  assign se[0] = ne[5];
  assign sf[0] = '0;
  assign ss[0] = ns[5];

  // One fraction bit per stage by squaring the Q1.31 mantissa.
  for (genvar j = 0; j < FW; j++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] p;
    assign sq = 64'(sm[j]) * 64'(sm[j]);
    assign p  = sq[63:31];
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else begin
        sv[j+1] <= sv[j];
      end
      se[j+1] <= se[j];
      ss[j+1] <= ss[j];
      if (p[32]) begin
        sm[j+1] <= p[32:1];
        sf[j+1] <= {sf[j][FW-2:0], 1'b1};
      end else begin
        sm[j+1] <= p[31:0];
        sf[j+1] <= {sf[j][FW-2:0], 1'b0};
      end
    end
  end

  assign out_valid = sv[FW];
  assign y         = {se[FW], sf[FW]};
  assign side_out  = ss[FW];

endmodule

[hdl/ntcbt_div.sv]
// ----------------------------------------------------------------------------
// ntcbt_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ntcbt_div #(
  parameter int NUM_W  = 47,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              v  [0:NUM_W];
  logic [NUM_W-1:0]  nq [0:NUM_W];
  logic [DEN_W-1:0]  rm [0:NUM_W];
  logic [DEN_W-1:0]  dv [0:NUM_W];
  logic [SIDE_W-1:0] sd [0:NUM_W];

  assign v[0]  = in_valid;
  assign nq[0] = num;
  assign rm[0] = '0;
  assign dv[0] = den;
  assign sd[0] = side_in;

  // Each stage brings down one numerator bit and shifts in one quotient bit.
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rm[k], nq[k][NUM_W-1]};
    assign ge    = trial >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      dv[k+1] <= dv[k];
      sd[k+1] <= sd[k];
      nq[k+1] <= {nq[k][NUM_W-2:0], ge};
      if (ge) begin
        rm[k+1] <= DEN_W'(trial - {1'b0, dv[k]});
      end else begin
        rm[k+1] <= trial[DEN_W-1:0];
      end
    end
  end

  assign out_valid = v[NUM_W];
  assign quo       = nq[NUM_W];
  assign side_out  = sd[NUM_W];

endmodule

[hdl/ntc_beta_temperature_top.sv]
// ----------------------------------------------------------------------------
// ntc_beta_temperature_top
// NTC thermistor resistance to Celsius by the beta equation, fully pipelined.
// ----------------------------------------------------------------------------
// A request is taken on every clock at which start is high; busy is always
// low. Each result appears 141 cycles later for one cycle with done high,
// and the receiver must take it then. The latency is set by the 33-stage
// log2 pipeline, the 47-stage divider for ln(R/R0)/B and 1/T0, and the
// 53-stage divider for the final reciprocal, plus eight stages of glue.
module ntc_beta_temperature_top #(
  parameter int RES_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [RES_BITS-1:0] resistance_ohms,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [19:0]         cfg_data,
  output logic                done,
  output logic signed [15:0]  temperature,
  output logic [1:0]          status
);

  localparam int SIDE_W = ntcbt_pkg::BETA_W + ntcbt_pkg::NOM_T_W + 2;

  // Configuration registers.
  logic [ntcbt_pkg::NOM_RES_W-1:0] nominal_resistance;
  logic [ntcbt_pkg::BETA_W-1:0]    beta_kelvin;
  logic [ntcbt_pkg::NOM_T_W-1:0]   nominal_temp_centikelvin;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_resistance       <= 20'd3000;
      beta_kelvin              <= 16'd3984;
      nominal_temp_centikelvin <= 16'd29815;
    end else if (cfg_we) begin
      case (ntcbt_pkg::cfg_index_t'(cfg_index))
        ntcbt_pkg::CFG_NOM_RES:  nominal_resistance       <= cfg_data;
        ntcbt_pkg::CFG_BETA:     beta_kelvin              <= cfg_data[15:0];
        ntcbt_pkg::CFG_NOM_TEMP: nominal_temp_centikelvin <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Entry stage: capture the request and classify early errors.
  logic                            e_valid;
  logic [RES_BITS-1:0]             e_r;
  logic [ntcbt_pkg::NOM_RES_W-1:0] e_r0;
  logic [ntcbt_pkg::BETA_W-1:0]    e_b;
  logic [ntcbt_pkg::NOM_T_W-1:0]   e_t0;
  ntcbt_pkg::status_t              e_err;
  ntcbt_pkg::status_t              e_err_next;

  always_comb begin
    if (resistance_ohms == '0) begin
      e_err_next = ntcbt_pkg::ST_ZERO_RES;
    end else if (nominal_resistance == '0 || beta_kelvin == '0 ||
                 nominal_temp_centikelvin == '0) begin
      e_err_next = ntcbt_pkg::ST_NONPOS;
    end else begin
      e_err_next = ntcbt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= start;
    end
    e_r   <= resistance_ohms;
    e_r0  <= nominal_resistance;
    e_b   <= beta_kelvin;
    e_t0  <= nominal_temp_centikelvin;
    e_err <= e_err_next;
  end

  // Logarithms of R and R0 in two parallel lanes.
  logic                          lg_valid;
  logic [ntcbt_pkg::LOG_W-1:0]   lr;
  logic [ntcbt_pkg::LOG_W-1:0]   l0;
  logic [SIDE_W-1:0]             lg_side;

  ntcbt_log2 #(.W(RES_BITS), .SIDE_W(SIDE_W)) u_log_r (
    .clk(clk), .rst(rst), .in_valid(e_valid), .x(e_r),
    .side_in({e_t0, e_b, e_err}),
    .out_valid(lg_valid), .y(lr), .side_out(lg_side)
  );

  ntcbt_log2 #(.W(ntcbt_pkg::NOM_RES_W), .SIDE_W(1)) u_log_r0 (
    .clk(clk), .rst(rst), .in_valid(e_valid), .x(e_r0), .side_in(1'b0),
    .out_valid(), .y(l0), .side_out()
  );

  // Difference of the logs as magnitude and sign.
  logic                        m1_valid;
  logic                        m1_neg;
  logic [ntcbt_pkg::LOG_W-1:0] m1_mag;
  logic [SIDE_W-1:0]           m1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= lg_valid;
    end
    m1_side <= lg_side;
    m1_neg  <= lr < l0;
    m1_mag  <= (lr < l0) ? (l0 - lr) : (lr - l0);
  end

  // Multiply by ln2 as two partial products.
  logic              m2_valid;
  logic              m2_neg;
  logic [43:0]       m2_plo;
  logic [44:0]       m2_phi;
  logic [SIDE_W-1:0] m2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_side <= m1_side;
    m2_neg  <= m1_neg;
    m2_plo  <= 44'(m1_mag[15:0]) * 44'(ntcbt_pkg::LN2_Q28);
    m2_phi  <= 45'(m1_mag[32:16]) * 45'(ntcbt_pkg::LN2_Q28);
  end

  // Combine the partial products and truncate to Q28.
  logic              m3_valid;
  logic              m3_neg;
  logic [32:0]       m3_lnq;
  logic [SIDE_W-1:0] m3_side;
  logic [60:0]       prod_sum;

  assign prod_sum = 61'(m2_plo) + (61'(m2_phi) << 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
    m3_side <= m2_side;
    m3_neg  <= m2_neg;
    m3_lnq  <= prod_sum[60:28];
  end

  // ln(R/R0)/B and 1/T0 in two parallel dividers.
  logic                      dv_valid;
  logic [ntcbt_pkg::Q_W-1:0] t1;
  logic [ntcbt_pkg::Q_W-1:0] t2;
  logic [2:0]                dv_side;

  ntcbt_div #(.NUM_W(ntcbt_pkg::Q_W), .DEN_W(ntcbt_pkg::BETA_W), .SIDE_W(3)) u_div_t1 (
    .clk(clk), .rst(rst), .in_valid(m3_valid),
    .num({2'b00, m3_lnq, 12'd0}), .den(m3_side[17:2]),
    .side_in({m3_neg, m3_side[1:0]}),
    .out_valid(dv_valid), .quo(t1), .side_out(dv_side)
  );

  ntcbt_div #(.NUM_W(ntcbt_pkg::Q_W), .DEN_W(ntcbt_pkg::NOM_T_W), .SIDE_W(1)) u_div_t2 (
    .clk(clk), .rst(rst), .in_valid(m3_valid),
    .num(ntcbt_pkg::T2_NUM), .den(m3_side[33:18]), .side_in(1'b0),
    .out_valid(), .quo(t2), .side_out()
  );

  // Denominator D and its sign check.
  logic signed [48:0]          d_sum;
  logic                        d_valid;
  logic [ntcbt_pkg::D_W-1:0]   d_den;
  ntcbt_pkg::status_t          d_err;
  ntcbt_pkg::status_t          dv_err;

  assign dv_err = ntcbt_pkg::status_t'(dv_side[1:0]);
  assign d_sum  = dv_side[2] ? (49'(t2) - 49'(t1)) : (49'(t2) + 49'(t1));

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= dv_valid;
    end
    d_den <= d_sum[47:0];
    if (dv_err != ntcbt_pkg::ST_OK) begin
      d_err <= dv_err;
    end else if (d_sum <= 0) begin
      d_err <= ntcbt_pkg::ST_NONPOS;
    end else begin
      d_err <= ntcbt_pkg::ST_OK;
    end
  end

  // Final reciprocal: kelvin in units of 1/6400.
  logic                        q_valid;
  logic [ntcbt_pkg::FIN_W-1:0] q;
  logic [1:0]                  q_side;

  ntcbt_div #(.NUM_W(ntcbt_pkg::FIN_W), .DEN_W(ntcbt_pkg::D_W), .SIDE_W(2)) u_div_q (
    .clk(clk), .rst(rst), .in_valid(d_valid),
    .num(ntcbt_pkg::FIN_NUM), .den(d_den), .side_in(d_err),
    .out_valid(q_valid), .quo(q), .side_out(q_side)
  );

  // Saturation check and rounding offset.
  logic                           p1_valid;
  logic                           p1_sat;
  logic [ntcbt_pkg::ROUND_W-1:0]  p1_x;
  logic [1:0]                     p1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= q_valid;
    end
    p1_err <= q_side;
    p1_sat <= q >= ntcbt_pkg::SAT_LIMIT;
    p1_x   <= q[22:0] + ntcbt_pkg::ROUND_ADD;
  end

  // Divide by 100 through the reciprocal.
  logic        p2_valid;
  logic        p2_sat;
  logic [16:0] p2_tu;
  logic [1:0]  p2_err;
  logic [46:0] recip_prod;

  assign recip_prod = 47'(p1_x) * 47'(ntcbt_pkg::RECIP_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_err <= p1_err;
    p2_sat <= p1_sat;
    p2_tu  <= recip_prod[46:30];
  end

  // Output register: offset to Celsius, clamp and status.
  logic [16:0] celsius;

  assign celsius = p2_tu - ntcbt_pkg::ABS_ZERO;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p2_valid;
    end
    if (ntcbt_pkg::status_t'(p2_err) != ntcbt_pkg::ST_OK) begin
      temperature <= '0;
      status      <= p2_err;
    end else if (p2_sat) begin
      temperature <= 16'sd32767;
      status      <= ntcbt_pkg::ST_SAT;
    end else begin
      temperature <= celsius[15:0];
      status      <= ntcbt_pkg::ST_OK;
    end
  end

endmodule
